### hdl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared helpers for the concurrent checks of the block allocator.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block allocator check failed");

// Next-cycle implication, disabled during reset.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block allocator check failed");

`endif

### hdl/bba_pkg.sv
// ============================================================================
// Block allocator package
// Shared widths, codes, state types and the command record.
// ============================================================================
package bba_pkg;

    localparam int DATA_W          = 20;
    localparam int BW              = 21;
    localparam int UNIT_W          = 8;
    localparam int POOL_W          = 13;
    localparam int CFG_W           = 13;
    localparam int CFG_IDX_W       = 1;
    localparam int STATUS_W        = 2;
    localparam int MAX_BLOCKS_DEF  = 4096;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 1'd1;

    localparam logic [UNIT_W-1:0] BLOCK_BYTES_RST = 8'd8;
    localparam logic [POOL_W-1:0] POOL_BLOCKS_RST = 13'd4096;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_ZERO
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] a;   // blocks needed or blocks freed
        logic [DATA_W-1:0] b;   // first block of a free
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_FIT,
        S_FREE,
        S_SC_RD,
        S_SC_BIT,
        S_MOD_RD,
        S_MOD_WR,
        S_MUL,
        S_FTAIL,
        S_WB_RD,
        S_WB_BIT,
        S_OUT
    } t_bstate;

endpackage

### hdl/bba_ram.sv
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data.
// ============================================================================
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

### hdl/bba_front.sv
// ============================================================================
// Allocator front end
// Accepts requests and turns byte sizes and offsets into block counts.
// ============================================================================
module bba_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bba_pkg::UNIT_W-1:0]  i_unit,
    input  logic                        i_clearing,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_kind,
    input  logic [bba_pkg::DATA_W-1:0]  i_size_bytes,
    input  logic [bba_pkg::DATA_W-1:0]  i_offset,
    output logic                        o_cmd_valid,
    input  logic                        i_cmd_ready,
    output bba_pkg::t_cmd               o_cmd
);

    localparam int DW    = bba_pkg::DATA_W;
    localparam int UW    = bba_pkg::UNIT_W;
    localparam int CNT_W = $clog2(DW);

    bba_pkg::t_fstate r_state, n_state;
    bba_pkg::t_cmd    r_cmd, n_cmd;
    logic             r_kind, n_kind;
    logic             r_phase, n_phase;
    logic [DW-1:0]    r_off, n_off;
    logic [DW-1:0]    r_dvd, n_dvd;
    logic [UW-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [UW:0]      w_trial;
    logic             w_qbit;
    logic [DW-1:0]    w_dvd;
    logic [DW-1:0]    w_quot;

    // One quotient bit per cycle, restoring division of (x - 1) by the unit.
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_qbit  = (w_trial >= {1'b0, i_unit});
    assign w_dvd   = {r_dvd[DW-2:0], w_qbit};
    assign w_quot  = w_dvd + DW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd   <= n_cmd;
        r_kind  <= n_kind;
        r_phase <= n_phase;
        r_off   <= n_off;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_kind      = r_kind;
        n_phase     = r_phase;
        n_off       = r_off;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        o_ready     = 1'b0;
        o_cmd_valid = 1'b0;
        case (r_state)
            bba_pkg::F_IDLE: begin
                o_ready = !i_clearing;
                if (i_valid && !i_clearing) begin
                    n_kind  = i_kind;
                    n_off   = i_offset;
                    n_cmd.a = '0;
                    n_cmd.b = '0;
                    n_cmd.op = i_kind ? bba_pkg::OP_FREE : bba_pkg::OP_ALLOC;
                    if (i_size_bytes == '0) begin
                        n_cmd.op = bba_pkg::OP_ZERO;
                        n_state  = bba_pkg::F_PUSH;
                    end else begin
                        n_dvd   = i_size_bytes - DW'(1);
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_phase = 1'b0;
                        n_state = bba_pkg::F_DIV;
                    end
                end
            end
            bba_pkg::F_DIV: begin
                n_dvd = w_dvd;
                n_rem = w_qbit ? UW'(w_trial - {1'b0, i_unit}) : UW'(w_trial);
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    if (!r_phase) begin
                        n_cmd.a = w_quot;
                        if (!r_kind || r_off == '0) begin
                            n_state = bba_pkg::F_PUSH;
                        end else begin
                            n_dvd   = r_off - DW'(1);
                            n_rem   = '0;
                            n_cnt   = '0;
                            n_phase = 1'b1;
                        end
                    end else begin
                        n_cmd.b = w_quot;
                        n_state = bba_pkg::F_PUSH;
                    end
                end
            end
            bba_pkg::F_PUSH: begin
                o_cmd_valid = 1'b1;
                if (i_cmd_ready) begin
                    n_state = bba_pkg::F_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::F_IDLE;
            end
        endcase
    end

    assign o_cmd = r_cmd;

endmodule

### hdl/bba_queue.sv
// ============================================================================
// Command queue
// Short FIFO of classified commands between the front and back ends.
// ============================================================================
module bba_queue #(
    parameter int DEPTH = bba_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  bba_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output bba_pkg::t_cmd o_pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bba_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

### hdl/bba_back.sv
// ============================================================================
// Allocator back end
// Runs commands against the used-bit map and returns one result each.
// ============================================================================
module bba_back #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bba_pkg::UNIT_W-1:0]    i_unit,
    input  logic [bba_pkg::POOL_W-1:0]    i_pool,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  bba_pkg::t_cmd                 i_cmd,
    output logic                          o_clearing,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bba_pkg::DATA_W-1:0]    o_result_offset,
    output logic [bba_pkg::STATUS_W-1:0]  o_status
);

    localparam int BW        = bba_pkg::BW;
    localparam int DW        = bba_pkg::DATA_W;
    localparam int SW        = bba_pkg::STATUS_W;
    localparam int UW        = bba_pkg::UNIT_W;
    localparam int MAP_BYTES = (MAX_BLOCKS + 7) / 8;
    localparam int MW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int IW        = $clog2(MAX_BLOCKS + 8);

    bba_pkg::t_bstate r_state, n_state;
    bba_pkg::t_cmd    r_cmd, n_cmd;
    logic [IW-1:0]    r_hint, n_hint;
    logic [IW-1:0]    r_top, n_top;
    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_run, n_run;
    logic [IW-1:0]    r_limit, n_limit;
    logic [IW-1:0]    r_first, n_first;
    logic [IW-1:0]    r_last, n_last;
    logic [IW-1:0]    r_back, n_back;
    logic             r_seen, n_seen;
    logic             r_set, n_set;
    logic [MW-1:0]    r_byte, n_byte;
    logic [DW-1:0]    r_res_off, n_res_off;
    logic [SW-1:0]    r_res_st, n_res_st;
    logic             r_ov, n_ov;
    logic [DW-1:0]    r_oo, n_oo;
    logic [SW-1:0]    r_os, n_os;

    logic             w_we, w_re;
    logic [MW-1:0]    w_waddr, w_raddr;
    logic [7:0]       w_wdata, w_rdata;

    logic [BW-1:0]    w_end, w_need, w_fit, w_limit, w_stop, w_hi, w_base, w_pos;
    logic [7:0]       w_mask;
    logic [IW-1:0]    w_nidx, w_runn, w_ffirst, w_bm1;
    logic [IW+UW-1:0] w_prod;
    logic             w_bit;

    bba_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_end   = (BW'(i_pool) > BW'(MAX_BLOCKS)) ? BW'(MAX_BLOCKS) : BW'(i_pool);
    assign w_need  = BW'(r_cmd.a);
    assign w_fit   = BW'(r_top) + w_need;
    assign w_limit = (BW'(r_top) < w_end) ? BW'(r_top) : w_end;
    assign w_stop  = BW'(r_cmd.b) + BW'(r_cmd.a);
    assign w_hi    = ((w_stop - BW'(1)) > BW'(MAX_BLOCKS - 1)) ? BW'(MAX_BLOCKS - 1)
                                                                : (w_stop - BW'(1));
    assign w_base  = BW'(r_byte) << 3;
    assign w_prod  = r_first * i_unit;
    assign w_bm1   = r_back - IW'(1);

    // Bits of the current map byte that fall inside the run being changed.
    always_comb begin
        w_pos = '0;
        for (int j = 0; j < 8; j++) begin
            w_pos     = w_base + BW'(j);
            w_mask[j] = (w_pos >= BW'(r_first)) && (w_pos <= BW'(r_last));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLR;
            r_byte  <= '0;
            r_hint  <= '0;
            r_top   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_byte  <= n_byte;
            r_hint  <= n_hint;
            r_top   <= n_top;
            r_ov    <= n_ov;
        end
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_run     <= n_run;
        r_limit   <= n_limit;
        r_first   <= n_first;
        r_last    <= n_last;
        r_back    <= n_back;
        r_seen    <= n_seen;
        r_set     <= n_set;
        r_res_off <= n_res_off;
        r_res_st  <= n_res_st;
        r_oo      <= n_oo;
        r_os      <= n_os;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_hint    = r_hint;
        n_top     = r_top;
        n_idx     = r_idx;
        n_run     = r_run;
        n_limit   = r_limit;
        n_first   = r_first;
        n_last    = r_last;
        n_back    = r_back;
        n_seen    = r_seen;
        n_set     = r_set;
        n_byte    = r_byte;
        n_res_off = r_res_off;
        n_res_st  = r_res_st;
        n_ov      = r_ov;
        n_oo      = r_oo;
        n_os      = r_os;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_waddr   = r_byte;
        w_raddr   = r_byte;
        w_wdata   = '0;
        w_nidx    = r_idx + IW'(1);
        w_runn    = '0;
        w_ffirst  = '0;
        w_bit     = 1'b0;
        o_cmd_ready = 1'b0;

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            bba_pkg::S_CLR: begin
                w_we = 1'b1;
                if (r_byte == MW'(MAP_BYTES - 1)) begin
                    n_byte  = '0;
                    n_state = bba_pkg::S_IDLE;
                end else begin
                    n_byte = r_byte + MW'(1);
                end
            end
            bba_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        bba_pkg::OP_ZERO: begin
                            n_res_st  = bba_pkg::ST_ZERO;
                            n_res_off = '0;
                            n_state   = bba_pkg::S_OUT;
                        end
                        bba_pkg::OP_ALLOC: n_state = bba_pkg::S_FIT;
                        default:           n_state = bba_pkg::S_FREE;
                    endcase
                end
            end
            bba_pkg::S_FREE: begin
                n_res_st  = bba_pkg::ST_OK;
                n_res_off = '0;
                if (BW'(r_cmd.b) < BW'(MAX_BLOCKS)) begin
                    n_first = IW'(r_cmd.b);
                    n_last  = IW'(w_hi);
                    n_byte  = MW'(r_cmd.b >> 3);
                    n_set   = 1'b0;
                    n_state = bba_pkg::S_MOD_RD;
                end else begin
                    n_state = bba_pkg::S_FTAIL;
                end
            end
            bba_pkg::S_FIT: begin
                if (w_fit <= w_end) begin
                    n_first = r_top;
                    n_last  = IW'(w_fit - BW'(1));
                    n_byte  = MW'(r_top >> 3);
                    n_set   = 1'b1;
                    n_state = bba_pkg::S_MOD_RD;
                end else begin
                    n_limit = IW'(w_limit);
                    n_idx   = r_hint;
                    n_run   = '0;
                    n_seen  = 1'b0;
                    if (BW'(r_hint) >= w_limit) begin
                        n_res_st  = bba_pkg::ST_NOSPACE;
                        n_res_off = '0;
                        n_state   = bba_pkg::S_OUT;
                    end else begin
                        n_state = bba_pkg::S_SC_RD;
                    end
                end
            end
            bba_pkg::S_SC_RD: begin
                w_re    = 1'b1;
                w_raddr = MW'(r_idx >> 3);
                n_state = bba_pkg::S_SC_BIT;
            end
            bba_pkg::S_SC_BIT: begin
                if (w_rdata == bba_pkg::FULL_BYTE) begin
                    // A full byte is passed over whole and breaks the run.
                    n_run  = '0;
                    w_nidx = (r_idx | IW'(7)) + IW'(1);
                end else begin
                    w_bit = w_rdata[r_idx[2:0]];
                    if (!w_bit) begin
                        if (!r_seen) begin
                            n_hint = r_idx;
                            n_seen = 1'b1;
                        end
                        w_runn = r_run + IW'(1);
                    end
                    n_run = w_runn;
                end
                w_ffirst = IW'(BW'(r_idx) - w_need + BW'(1));
                if (w_rdata != bba_pkg::FULL_BYTE && BW'(w_runn) >= w_need) begin
                    n_first = w_ffirst;
                    n_last  = r_idx;
                    n_byte  = MW'(w_ffirst >> 3);
                    n_set   = 1'b1;
                    n_state = bba_pkg::S_MOD_RD;
                end else begin
                    n_idx = w_nidx;
                    if (w_nidx >= r_limit) begin
                        n_res_st  = bba_pkg::ST_NOSPACE;
                        n_res_off = '0;
                        n_state   = bba_pkg::S_OUT;
                    end else if (w_nidx[2:0] == 3'd0) begin
                        n_state = bba_pkg::S_SC_RD;
                    end
                end
            end
            bba_pkg::S_MOD_RD: begin
                w_re    = 1'b1;
                n_state = bba_pkg::S_MOD_WR;
            end
            bba_pkg::S_MOD_WR: begin
                w_we    = 1'b1;
                w_wdata = r_set ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
                if (BW'(r_byte) == (BW'(r_last) >> 3)) begin
                    if (r_set) begin
                        if (r_last >= r_top) begin
                            n_top = r_last + IW'(1);
                        end
                        n_state = bba_pkg::S_MUL;
                    end else begin
                        n_state = bba_pkg::S_FTAIL;
                    end
                end else begin
                    n_byte  = r_byte + MW'(1);
                    n_state = bba_pkg::S_MOD_RD;
                end
            end
            bba_pkg::S_MUL: begin
                n_res_off = DW'(w_prod);
                n_res_st  = bba_pkg::ST_OK;
                n_state   = bba_pkg::S_OUT;
            end
            bba_pkg::S_FTAIL: begin
                if (BW'(r_cmd.b) < BW'(r_hint)) begin
                    n_hint = IW'(r_cmd.b);
                end
                if (w_stop == BW'(r_top)) begin
                    if (r_cmd.b == '0) begin
                        n_top   = '0;
                        n_state = bba_pkg::S_OUT;
                    end else begin
                        n_back  = IW'(r_cmd.b);
                        n_state = bba_pkg::S_WB_RD;
                    end
                end else begin
                    n_state = bba_pkg::S_OUT;
                end
            end
            bba_pkg::S_WB_RD: begin
                w_re    = 1'b1;
                w_raddr = MW'(w_bm1 >> 3);
                n_state = bba_pkg::S_WB_BIT;
            end
            bba_pkg::S_WB_BIT: begin
                w_bit = w_rdata[w_bm1[2:0]];
                if (w_bit) begin
                    n_top   = r_back;
                    n_state = bba_pkg::S_OUT;
                end else if (w_bm1 == '0) begin
                    n_top   = '0;
                    n_state = bba_pkg::S_OUT;
                end else begin
                    n_back = w_bm1;
                    // Stepping below a byte boundary needs the next lower byte.
                    if (w_bm1[2:0] == 3'd0) begin
                        n_state = bba_pkg::S_WB_RD;
                    end
                end
            end
            bba_pkg::S_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_oo    = r_res_off;
                    n_os    = r_res_st;
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_clearing      = (r_state == bba_pkg::S_CLR);
    assign o_valid         = r_ov;
    assign o_result_offset = r_oo;
    assign o_status        = r_os;

endmodule

### hdl/bitmap_block_allocator_unit.sv
// ============================================================================
// Bitmap block allocator
// Used-bit map allocator of equal blocks: at the top mark, else first-fit.
// ============================================================================
//  channel  | direction | handshake            | payload
//  request  | in        | i_valid / o_ready    | i_kind, i_size_bytes, i_offset
//  result   | out       | o_valid / i_ready    | o_result_offset, o_status
//  config   | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// The front end runs one division for an allocate and two for a free at a
// nonzero offset; a zero-size request skips division.
// The back end updates the map by reading and writing each map byte; a scan
// reads map bytes and tests one bit at a time (a full byte is one test),
// and a top walk-back tests bits downwards, reading a map byte as needed.
// After reset all map bytes are swept clear, and no request is taken until
// then; configuration writes are taken always. A two-entry command queue and
// the result register let both ends stall apart.
`include "assert_macros.svh"

module bitmap_block_allocator_unit #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bba_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  logic [bba_pkg::DATA_W-1:0]      i_size_bytes,
    input  logic [bba_pkg::DATA_W-1:0]      i_offset,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bba_pkg::DATA_W-1:0]      o_result_offset,
    output logic [bba_pkg::STATUS_W-1:0]    o_status
);

    localparam int UW = bba_pkg::UNIT_W;
    localparam int PW = bba_pkg::POOL_W;

    logic [UW-1:0]  r_block_bytes;
    logic [PW-1:0]  r_pool_blocks;
    logic [UW-1:0]  w_unit;
    logic           w_clearing;
    logic           w_push_valid, w_push_ready, w_pop_valid, w_pop_ready;
    bba_pkg::t_cmd  w_push_cmd, w_pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= bba_pkg::BLOCK_BYTES_RST;
            r_pool_blocks <= bba_pkg::POOL_BLOCKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bba_pkg::CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data[UW-1:0];
                bba_pkg::CFG_POOL_BLOCKS: r_pool_blocks <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // A block size of zero behaves as one byte.
    assign w_unit = (r_block_bytes == '0) ? UW'(1) : r_block_bytes;

    bba_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_unit       (w_unit),
        .i_clearing   (w_clearing),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_size_bytes (i_size_bytes),
        .i_offset     (i_offset),
        .o_cmd_valid  (w_push_valid),
        .i_cmd_ready  (w_push_ready),
        .o_cmd        (w_push_cmd)
    );

    bba_queue #(
        .DEPTH (bba_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    bba_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_unit          (w_unit),
        .i_pool          (r_pool_blocks),
        .i_cmd_valid     (w_pop_valid),
        .o_cmd_ready     (w_pop_ready),
        .i_cmd           (w_pop_cmd),
        .o_clearing      (w_clearing),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_offset (o_result_offset),
        .o_status        (o_status)
    );

    `BBA_ASSERT_IMP(a_no_req_in_clear, i_clk, i_rst_n, o_ready, !w_clearing)
    `BBA_ASSERT_IMP(a_fail_zero_off, i_clk, i_rst_n, o_valid && (o_status != bba_pkg::ST_OK), o_result_offset == '0)
    `BBA_ASSERT_NEXT(a_clear_once, i_clk, i_rst_n, !w_clearing, !w_clearing)

endmodule
